// ===== sv/odi_pkg.sv =====
// Shared types, constants and helpers of the occupancy disk inflation block.
`default_nettype none
package odi_pkg;

	localparam int COORD_W = 8;
	localparam int VAL_W   = 8;
	localparam int CFG_W   = 9;
	localparam int RAD_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_RADIUS = 15;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd256;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd256;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd0;

	localparam logic signed [VAL_W-1:0] OCC_VALUE     = 8'sd100;
	localparam logic signed [VAL_W-1:0] UNKNOWN_VALUE = -8'sd1;
	localparam logic signed [VAL_W-1:0] FREE_VALUE    = 8'sd0;

	typedef struct packed {
		logic                      opcode;
		logic [COORD_W-1:0]        col;
		logic [COORD_W-1:0]        row;
		logic signed [VAL_W-1:0]   cell_value;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0]        out_col;
		logic [COORD_W-1:0]        out_row;
		logic signed [VAL_W-1:0]   inflated_value;
		logic                      out_of_grid;
	} result_t;

	typedef struct packed {
		logic probe;
		logic last;
	} walk_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CENTER
	} state_t;

	function automatic logic is_obstacle(input logic signed [VAL_W-1:0] v);
		return (v == OCC_VALUE) || (v == UNKNOWN_VALUE);
	endfunction

endpackage
`default_nettype wire

// ===== sv/odi_store.sv =====
// Grid cell store: one write port, one registered read port.
`default_nettype none
module odi_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [odi_pkg::VAL_W-1:0]    wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [odi_pkg::VAL_W-1:0]    rdata
);
	import odi_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/odi_walk.sv =====
// Neighborhood walker: offset counters, incremental disk test, bounds check, address.
`default_nettype none
module odi_walk #(
	parameter int MAX_WIDTH  = odi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = odi_pkg::DEF_MAX_RADIUS,
	parameter int AW         = 16,
	parameter int EW         = 9
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [odi_pkg::COORD_W-1:0]   col,
	input  logic [odi_pkg::COORD_W-1:0]   row,
	input  logic [odi_pkg::RAD_W-1:0]     radius,
	input  logic [EW-1:0]                 w_eff,
	input  logic [EW-1:0]                 h_eff,
	output odi_pkg::walk_stat_t           stat,
	output logic [AW-1:0]                 addr,
	output logic [AW-1:0]                 center_addr
);
	import odi_pkg::*;

	localparam int RW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int DW  = RW + 1;
	localparam int SQW = 2 * RW;
	localparam int RMX = (RW > RAD_W) ? RW : RAD_W;
	localparam int NW  = ((COORD_W > DW) ? COORD_W : DW) + 2;
	localparam int CW  = (NW > EW + 1) ? NW : EW + 1;

	// next square from the current one: (d+1)^2 = d^2 + 2d + 1
	function automatic logic [SQW-1:0] sq_next(input logic [SQW-1:0] sq,
			input logic signed [DW-1:0] d);
		logic signed [SQW+1:0] s;
		s = $signed({2'b00, sq}) + ((SQW+2)'(d) <<< 1) + (SQW+2)'(1);
		return s[SQW-1:0];
	endfunction

	logic [RMX-1:0]          rad_wide;
	logic [RW-1:0]           rad_eff;
	logic [SQW-1:0]          rad_sq;
	logic signed [DW-1:0]    neg_rad;
	logic signed [DW-1:0]    rad_s;

	logic [RW-1:0]           rad_q;
	logic [SQW-1:0]          rsq_q;
	logic signed [DW-1:0]    dx_q;
	logic signed [DW-1:0]    dy_q;
	logic [SQW-1:0]          dxsq_q;
	logic [SQW-1:0]          dysq_q;
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;

	logic [SQW:0]            sq_sum;
	logic                    in_disk;
	logic signed [NW-1:0]    nc;
	logic signed [NW-1:0]    nr;
	logic signed [CW-1:0]    ncx;
	logic signed [CW-1:0]    nrx;
	logic signed [CW-1:0]    wx;
	logic signed [CW-1:0]    hx;
	logic                    in_bounds;

	assign rad_wide = (RMX'(radius) < RMX'(MAX_RADIUS)) ? RMX'(radius) : RMX'(MAX_RADIUS);
	assign rad_eff  = rad_wide[RW-1:0];
	assign rad_sq   = SQW'(rad_eff) * SQW'(rad_eff);
	assign neg_rad  = -$signed({1'b0, rad_eff});
	assign rad_s    = $signed({1'b0, rad_q});

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= rad_eff;
			rsq_q  <= rad_sq;
			dx_q   <= neg_rad;
			dy_q   <= neg_rad;
			dxsq_q <= rad_sq;
			dysq_q <= rad_sq;
			col_q  <= col;
			row_q  <= row;
		end else if (step) begin
			if (dx_q == rad_s) begin
				dx_q   <= -rad_s;
				dxsq_q <= rsq_q;
				dy_q   <= dy_q + DW'(1);
				dysq_q <= sq_next(dysq_q, dy_q);
			end else begin
				dx_q   <= dx_q + DW'(1);
				dxsq_q <= sq_next(dxsq_q, dx_q);
			end
		end
	end

	assign sq_sum  = {1'b0, dxsq_q} + {1'b0, dysq_q};
	assign in_disk = sq_sum <= {1'b0, rsq_q};

	assign nc  = $signed({{(NW-COORD_W){1'b0}}, col_q}) + NW'(dx_q);
	assign nr  = $signed({{(NW-COORD_W){1'b0}}, row_q}) + NW'(dy_q);
	assign ncx = CW'(nc);
	assign nrx = CW'(nr);
	assign wx  = $signed(CW'(w_eff));
	assign hx  = $signed(CW'(h_eff));
	assign in_bounds = (ncx >= 0) && (ncx < wx) && (nrx >= 0) && (nrx < hx);

	assign stat.probe = in_disk && in_bounds;
	assign stat.last  = (dx_q == rad_s) && (dy_q == rad_s);

	assign addr        = AW'(nr) * AW'(MAX_WIDTH) + AW'(nc);
	assign center_addr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);

endmodule
`default_nettype wire

// ===== sv/occupancy_disk_inflation_core.sv =====
// Top level of the occupancy disk inflation block: sequencer, registers, result port.
//
// Obstacle inflation over an occupancy grid held in an internal cell store. A
// command transfers at a rising edge with start high and busy low. A write
// command stores cell_value at (col,row) and produces no result; busy stays
// low. A query outside the configured grid returns its result in the next
// cycle, also without raising busy. A query inside the grid walks the
// (2R+1) x (2R+1) square around the cell, reading the store only at offsets
// inside the disk dx*dx+dy*dy <= R*R and inside the grid, then reads the
// center cell once more; no new command is taken until it ends. The walk
// ends early when an obstacle (100 or -1) is found. The store has a single
// read port. Each result is on result for exactly one cycle with done high; the
// receiver must take it then, it cannot stall the block. Cells must be written
// before any query reads them; the store has no reset. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and are meant for idle time.
`default_nettype none
module occupancy_disk_inflation_core #(
	parameter int MAX_WIDTH  = odi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = odi_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = odi_pkg::DEF_MAX_RADIUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  odi_pkg::cmd_t                   cmd,
	output logic                            done,
	output odi_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [odi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [odi_pkg::CFG_W-1:0]       cfg_data
);
	import odi_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EWW   = $clog2(MAX_WIDTH + 1);
	localparam int EWH   = $clog2(MAX_HEIGHT + 1);
	localparam int EWM   = (EWW > EWH) ? EWW : EWH;
	localparam int EW    = (EWM > CFG_W) ? EWM : CFG_W;

	// configuration registers
	logic [CFG_W-1:0]  grid_width_q;
	logic [CFG_W-1:0]  grid_height_q;
	logic [RAD_W-1:0]  radius_q;

	// sequencer
	state_t            state_q;
	state_t            state_d;
	logic              rd_pend_q;

	// query coordinates, held for the result
	logic [COORD_W-1:0] qcol_q;
	logic [COORD_W-1:0] qrow_q;

	// result register
	logic              done_q;
	result_t           result_q;

	logic              accept;
	logic [EW-1:0]     w_eff;
	logic [EW-1:0]     h_eff;
	logic              oog;
	logic              wr_in_store;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic              rd_center;
	logic [AW-1:0]     rd_addr;
	logic signed [VAL_W-1:0] rdata;

	logic              walk_load;
	logic              walk_step;
	walk_stat_t        walk_stat;
	logic [AW-1:0]     walk_addr;
	logic [AW-1:0]     center_addr;

	logic              fin;
	logic signed [VAL_W-1:0] fin_val;
	logic              fin_oog;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// effective grid size: clamp the registers to the physical store
	assign w_eff = (EW'(grid_width_q) < EW'(MAX_WIDTH)) ? EW'(grid_width_q) : EW'(MAX_WIDTH);
	assign h_eff = (EW'(grid_height_q) < EW'(MAX_HEIGHT)) ? EW'(grid_height_q) : EW'(MAX_HEIGHT);
	assign oog   = (EW'(cmd.col) >= w_eff) || (EW'(cmd.row) >= h_eff);

	// drop writes that fall beyond the physical store
	assign wr_in_store = (EW'(cmd.col) < EW'(MAX_WIDTH)) && (EW'(cmd.row) < EW'(MAX_HEIGHT));
	assign mem_we      = accept && (cmd.opcode == OP_WRITE) && wr_in_store;
	assign wr_addr     = AW'(cmd.row) * AW'(MAX_WIDTH) + AW'(cmd.col);

	assign rd_addr = rd_center ? center_addr : walk_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_RESET;
			grid_height_q <= HEIGHT_RESET;
			radius_q      <= RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  grid_width_q  <= cfg_data;
				REG_HEIGHT: grid_height_q <= cfg_data;
				REG_RADIUS: radius_q      <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= rd_en;
			done_q    <= fin;
		end
	end

	// payload: capture query coordinates on transfer, the result on finish
	always_ff @(posedge clk) begin
		if (accept) begin
			qcol_q <= cmd.col;
			qrow_q <= cmd.row;
		end
		if (fin) begin
			result_q.out_col        <= (state_q == ST_IDLE) ? cmd.col : qcol_q;
			result_q.out_row        <= (state_q == ST_IDLE) ? cmd.row : qrow_q;
			result_q.inflated_value <= fin_val;
			result_q.out_of_grid    <= fin_oog;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		walk_load = 1'b0;
		walk_step = 1'b0;
		rd_en     = 1'b0;
		rd_center = 1'b0;
		fin       = 1'b0;
		fin_val   = rdata;
		fin_oog   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.opcode == OP_QUERY)) begin
					if (oog) begin
						// outside the grid: answer at once, no walk
						fin     = 1'b1;
						fin_val = FREE_VALUE;
						fin_oog = 1'b1;
					end else begin
						walk_load = 1'b1;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (rd_pend_q && is_obstacle(rdata)) begin
					// obstacle in the disk: stop the walk
					fin     = 1'b1;
					fin_val = OCC_VALUE;
					state_d = ST_IDLE;
				end else begin
					rd_en     = walk_stat.probe;
					walk_step = !walk_stat.last;
					if (walk_stat.last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// check the last neighbor read, then fetch the center cell
				if (rd_pend_q && is_obstacle(rdata)) begin
					fin     = 1'b1;
					fin_val = OCC_VALUE;
					state_d = ST_IDLE;
				end else begin
					rd_en     = 1'b1;
					rd_center = 1'b1;
					state_d   = ST_CENTER;
				end
			end
			ST_CENTER: begin
				fin     = 1'b1;
				fin_val = rdata;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	odi_walk #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS),
		.AW         (AW),
		.EW         (EW)
	) u_walk (
		.clk         (clk),
		.load        (walk_load),
		.step        (walk_step),
		.col         (cmd.col),
		.row         (cmd.row),
		.radius      (radius_q),
		.w_eff       (w_eff),
		.h_eff       (h_eff),
		.stat        (walk_stat),
		.addr        (walk_addr),
		.center_addr (center_addr)
	);

	odi_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (cmd.cell_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (($past(state_q) != ST_IDLE) || $past(start && cmd.opcode == OP_QUERY)))
		else $error("result strobe without a query");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("store written during a walk");

	a_oog_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_of_grid) |-> (result.inflated_value == FREE_VALUE))
		else $error("out-of-grid result carries a nonzero value");
`endif

endmodule
`default_nettype wire

// ===== verif/odi_checker.sv =====
// Checker for the occupancy disk inflation block: shadow grid, inflation predictor, result compare.
`default_nettype none
module odi_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  odi_pkg::cmd_t                 cmd,
	input  logic                          done,
	input  odi_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [odi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [odi_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            checked,
	output int                            outside_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import odi_pkg::*;

	logic [CFG_W-1:0]        width_reg;
	logic [CFG_W-1:0]        height_reg;
	logic [RAD_W-1:0]        radius_reg;
	logic signed [VAL_W-1:0] grid_cells [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
	result_t                 pending_inflations [$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		checked      = 0;
		outside_seen = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// Inflated value of one queried cell under the current register settings.
	function automatic result_t inflate_cell(input cmd_t q);
		result_t                 r;
		int                      w;
		int                      h;
		int                      rad;
		int                      nc;
		int                      nr;
		logic                    hit;
		logic signed [VAL_W-1:0] v;

		w   = (int'(width_reg) < DEF_MAX_WIDTH) ? int'(width_reg) : DEF_MAX_WIDTH;
		h   = (int'(height_reg) < DEF_MAX_HEIGHT) ? int'(height_reg) : DEF_MAX_HEIGHT;
		rad = (int'(radius_reg) < DEF_MAX_RADIUS) ? int'(radius_reg) : DEF_MAX_RADIUS;
		r.out_col = q.col;
		r.out_row = q.row;
		if (int'(q.col) >= w || int'(q.row) >= h) begin
			r.inflated_value = FREE_VALUE;
			r.out_of_grid    = 1'b1;
			return r;
		end
		hit = 1'b0;
		for (int dy = -rad; dy <= rad; dy++) begin
			for (int dx = -rad; dx <= rad; dx++) begin
				nc = int'(q.col) + dx;
				nr = int'(q.row) + dy;
				if (dx * dx + dy * dy <= rad * rad && nc >= 0 && nc < w && nr >= 0 && nr < h)
				begin
					v = grid_cells[nr * DEF_MAX_WIDTH + nc];
					if (v == OCC_VALUE || v == UNKNOWN_VALUE)
						hit = 1'b1;
				end
			end
		end
		r.inflated_value = hit ? OCC_VALUE
			: grid_cells[int'(q.row) * DEF_MAX_WIDTH + int'(q.col)];
		r.out_of_grid = 1'b0;
		return r;
	endfunction

	task automatic check_result(input result_t got);
		result_t want;

		if (pending_inflations.size() == 0) begin
			flag_mismatch($sformatf("result for (%0d,%0d) with no query outstanding",
				got.out_col, got.out_row));
			return;
		end
		want = pending_inflations.pop_front();
		checked++;
		if (got.out_of_grid === 1'b1)
			outside_seen++;
		if (got.out_col !== want.out_col)
			flag_mismatch($sformatf("out_col of query (%0d,%0d): got %0d, expected %0d",
				want.out_col, want.out_row, got.out_col, want.out_col));
		if (got.out_row !== want.out_row)
			flag_mismatch($sformatf("out_row of query (%0d,%0d): got %0d, expected %0d",
				want.out_col, want.out_row, got.out_row, want.out_row));
		if (got.inflated_value !== want.inflated_value)
			flag_mismatch($sformatf("inflated_value of query (%0d,%0d): got %0d, expected %0d",
				want.out_col, want.out_row, got.inflated_value, want.inflated_value));
		if (got.out_of_grid !== want.out_of_grid)
			flag_mismatch($sformatf("out_of_grid of query (%0d,%0d): got %0d, expected %0d",
				want.out_col, want.out_row, got.out_of_grid, want.out_of_grid));
	endtask

	// Retire the result first: it never belongs to a query taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			radius_reg = RADIUS_RESET;
		end else begin
			if (done)
				check_result(result);
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_RADIUS: radius_reg = cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (cmd.opcode == OP_WRITE)
					grid_cells[{cmd.row, cmd.col}] = cmd.cell_value;
				else
					pending_inflations = {pending_inflations, inflate_cell(cmd)};
			end
			pending = pending_inflations.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_occupancy_disk_inflation_core.sv =====
// Testbench top of the occupancy disk inflation block: stimulus, watchdog and verdict.
`default_nettype none
module tb_occupancy_disk_inflation_core;
	timeunit 1ns;
	timeprecision 1ps;

	import odi_pkg::*;

	localparam int ITEM_TARGET   = 620;
	localparam int IDLE_LIMIT    = 20000; // cycles without any transfer or result
	localparam int SETTLE_CYCLES = 4;     // a write is stored at its own transfer
	localparam int DRAIN_CYCLES  = 1000;  // longer than the slowest query walk

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	cmd_t                 cmd       = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 done;
	result_t              result;

	int fail_count;
	int pending;
	int checked;
	int outside_seen;

	// Stimulus-side view of the grid: which cells hold a defined value, and the
	// effective grid size and radius, so that no query walks over an unwritten cell.
	bit written_map [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
	int eff_w        = DEF_MAX_WIDTH;
	int eff_h        = DEF_MAX_HEIGHT;
	int eff_rad      = 0;
	int obstacle_pct = 10;
	bit burst_mode   = 1'b0;

	int n_items    = 0;
	int n_writes   = 0;
	int n_queries  = 0;
	int n_settings = 0;
	int idle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	occupancy_disk_inflation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	odi_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.outside_seen (outside_seen)
	);

	// Watchdog: a hung handshake or a lost result stops the run here.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= IDLE_LIMIT) begin
				$display("watchdog: %0d cycles without a transfer, %0d results outstanding",
					idle_count, pending);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Present one command at a falling edge and hold it until the transfer.
	// Start stays high into the next call when that one draws no gap.
	task automatic issue_cmd(input cmd_t c);
		int gap;

		gap = burst_mode ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
	endtask

	// Drop start, wait for every outstanding result, then let a write retire.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		start     <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reprogram all three registers with the block idle; track the effective values.
	task automatic set_grid(input int w, input int h, input int r);
		settle();
		set_reg(REG_WIDTH, w);
		set_reg(REG_HEIGHT, h);
		set_reg(REG_RADIUS, r);
		eff_w   = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		eff_h   = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
		eff_rad = (r > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : r;
		n_settings++;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return OCC_VALUE;
			1: return UNKNOWN_VALUE;
			2: return FREE_VALUE;
			default: return VAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Background cells: mostly free values, obstacles at the phase's rate.
	function automatic logic signed [VAL_W-1:0] fill_value();
		logic signed [VAL_W-1:0] v;

		if ($urandom_range(0, 99) < obstacle_pct)
			return ($urandom_range(0, 1) != 0) ? OCC_VALUE : UNKNOWN_VALUE;
		do
			v = VAL_W'($urandom_range(0, 255));
		while (v == OCC_VALUE || v == UNKNOWN_VALUE);
		return v;
	endfunction

	task automatic write_cell(input int c, input int r, input logic signed [VAL_W-1:0] v);
		cmd_t w;

		w.opcode     = OP_WRITE;
		w.col        = COORD_W'(c);
		w.row        = COORD_W'(r);
		w.cell_value = v;
		issue_cmd(w);
		written_map[r * DEF_MAX_WIDTH + c] = 1'b1;
		n_writes++;
	endtask

	function automatic bit in_grid(input int c, input int r);
		return c >= 0 && c < eff_w && r >= 0 && r < eff_h;
	endfunction

	// Write every in-grid cell of the disk around (c,r) that has no value yet.
	task automatic fill_disk(input int c, input int r);
		int nc;
		int nr;

		for (int dy = -eff_rad; dy <= eff_rad; dy++) begin
			for (int dx = -eff_rad; dx <= eff_rad; dx++) begin
				nc = c + dx;
				nr = r + dy;
				if (dx * dx + dy * dy <= eff_rad * eff_rad && in_grid(nc, nr)
					&& !written_map[nr * DEF_MAX_WIDTH + nc])
					write_cell(nc, nr, fill_value());
			end
		end
	endtask

	// Query one cell; inside the grid, make its whole disk defined first.
	task automatic query_cell(input int c, input int r);
		cmd_t q;

		if (in_grid(c, r))
			fill_disk(c, r);
		q.opcode     = OP_QUERY;
		q.col        = COORD_W'(c);
		q.row        = COORD_W'(r);
		q.cell_value = VAL_W'($urandom_range(0, 255));
		issue_cmd(q);
		n_queries++;
	endtask

	initial begin
		int kind;
		int w;
		int h;
		int r;
		int tmp;
		int phase_len;
		int c;
		int rw;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, radius 0: each query reads only its own cell.
		// Extreme corners and values, including non-obstacle neighbors of 100.
		write_cell(0, 0, OCC_VALUE);
		write_cell(255, 255, UNKNOWN_VALUE);
		write_cell(255, 0, -8'sd128);
		write_cell(0, 255, 8'sd127);
		write_cell(1, 0, FREE_VALUE);
		write_cell(128, 64, 8'sd99);
		write_cell(128, 65, 8'sd101);
		query_cell(0, 0);
		query_cell(255, 255);
		query_cell(255, 0);
		query_cell(0, 255);
		query_cell(1, 0);
		query_cell(128, 64);
		query_cell(128, 65);

		// Tiny grid at the largest radius: the disk covers the whole grid.
		// Probe just past each edge and far outside.
		set_grid(4, 4, DEF_MAX_RADIUS);
		query_cell(0, 0);
		query_cell(3, 3);
		query_cell(4, 0);
		query_cell(0, 4);
		query_cell(200, 3);
		query_cell(3, 200);

		// Zero width: every query falls outside.
		set_grid(0, 256, 0);
		query_cell(0, 0);

		// Sizes beyond the store clamp to the full grid.
		set_grid(511, 300, 1);
		query_cell(255, 255);
		query_cell(255, 0);

		// Single cell grid.
		set_grid(1, 1, 2);
		query_cell(0, 0);
		query_cell(1, 0);

		// Disk versus square: an obstacle on the diagonal corner at radius 2 lies
		// outside the disk, one on the axis at distance 2 lies on its rim.
		obstacle_pct = 0;
		set_grid(256, 256, 2);
		write_cell(102, 102, OCC_VALUE);
		query_cell(100, 100);
		query_cell(100, 102);
		query_cell(104, 104);

		// Random phases: new settings each time, then writes mixed with queries
		// that mostly land inside the grid.
		while (n_items < ITEM_TARGET) begin
			kind = $urandom_range(0, 3);
			case (kind)
				0: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 12);
					r = $urandom_range(0, DEF_MAX_RADIUS);
				end
				1: begin
					w = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
						: $urandom_range(1, 256);
					h = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
						: $urandom_range(1, 256);
					r = $urandom_range(0, 2);
				end
				2: begin
					w = $urandom_range(1, 32);
					h = $urandom_range(1, 32);
					r = $urandom_range(0, 4);
				end
				default: begin
					w = $urandom_range(0, 2);
					h = $urandom_range(0, 300);
					r = $urandom_range(0, DEF_MAX_RADIUS);
					if ($urandom_range(0, 1) != 0) begin
						tmp = w;
						w   = h;
						h   = tmp;
					end
				end
			endcase
			set_grid(w, h, r);
			obstacle_pct = $urandom_range(0, 15);
			burst_mode   = ($urandom_range(0, 3) == 0);
			phase_len    = $urandom_range(20, 60);
			repeat (phase_len) begin
				// Stop the phase once the item budget is spent.
				if (n_items >= ITEM_TARGET)
					break;
				// Now and then hold off until the block has nothing outstanding.
				if ($urandom_range(0, 39) == 0)
					settle();
				if (eff_w > 0 && eff_h > 0 && $urandom_range(0, 6) != 0) begin
					c = $urandom_range(0, eff_w - 1);
					rw = $urandom_range(0, eff_h - 1);
				end else begin
					c = $urandom_range(0, 255);
					rw = $urandom_range(0, 255);
				end
				if ($urandom_range(0, 99) < 35)
					write_cell(c, rw, pick_value());
				else
					query_cell(c, rw);
			end
		end

		// Wait out every result, then watch for anything stray.
		burst_mode = 1'b0;
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d cell writes and %0d queries over %0d register settings",
			n_writes, n_queries, n_settings);
		$display("Checked %0d inflated results, %0d of them outside the grid",
			checked, outside_seen);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/odi_pkg.sv
sv/odi_store.sv
sv/odi_walk.sv
sv/occupancy_disk_inflation_core.sv
verif/odi_checker.sv
verif/tb_occupancy_disk_inflation_core.sv
